// ===== rtl/core/rainbow_ring_pixel_color_assert.svh =====
// ----------------------------------------------------------------------------
// Rainbow ring assertion macros
// Shared concurrent check templates for the rainbow ring pixel color block.
// ----------------------------------------------------------------------------
`ifndef RAINBOW_RING_PIXEL_COLOR_ASSERT_SVH
`define RAINBOW_RING_PIXEL_COLOR_ASSERT_SVH

// same-cycle implication, quiet during reset
`define RRPC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrpc: same-cycle check failed");

// next-cycle implication, quiet during reset
`define RRPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrpc: next-cycle check failed");

`endif

// ===== rtl/core/rrpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rainbow ring pixel color package
// Shared widths, CORDIC constants and the divider beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package rrpc_pkg;

  // matrix geometry defaults
  localparam int DEFAULT_MATRIX_WIDTH  = 64;
  localparam int DEFAULT_MATRIX_HEIGHT = 32;

  // cordic geometry
  localparam int CORDIC_ITERS = 16;
  localparam int VEC_W        = 24;  // vectoring x/y, covers the default matrix size
  localparam int ROT_W        = 19;  // rotation x/y
  localparam int ANG_W        = 18;  // rotation residual angle
  localparam int COS_W        = 18;  // clamped cosine, Q16 signed
  localparam int Q_W          = 17;  // unsigned Q16 values up to one
  localparam int W_W          = 16;  // ring half width in Q16

  localparam logic [16:0] CORDIC_GAIN_INV = 17'd39797;

  // arctangent of 2^-i in turns of 65536
  localparam logic [13:0] ATAN_TURNS [CORDIC_ITERS] = '{
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
    14'd41,   14'd20,   14'd10,   14'd5,    14'd3,   14'd1,   14'd1,   14'd0
  };

  // register reset values
  localparam logic [12:0] RING_RADIUS_RESET = 13'd1229;
  localparam logic [11:0] RING_WIDTH_RESET  = 12'd410;

  // configuration register indexes
  typedef enum logic {
    REG_RING_RADIUS = 1'b0,
    REG_RING_WIDTH  = 1'b1
  } cfg_reg_t;

  // one beat of the mask divider chain
  typedef struct packed {
    logic           kill;
    logic [W_W-1:0] w;
    logic [Q_W-1:0] rem;
    logic [Q_W-1:0] quo;
  } div_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrpc_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation of a CORDIC chain, vectoring or rotation mode, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rrpc_cordic_cell import rrpc_pkg::*; #(
  parameter int DW     = ROT_W,
  parameter int ZW     = ANG_W,
  parameter int ITER   = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic                 clk,
  input  logic signed [DW-1:0] x_in,
  input  logic signed [DW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [DW-1:0] x_out,
  output logic signed [DW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  localparam logic signed [ZW-1:0] STEP = ZW'(ATAN_TURNS[ITER]);

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic                 ccw;

  // shifted terms and rotation sense
  always_comb begin
    dx  = y_in >>> ITER;
    dy  = x_in >>> ITER;
    ccw = VECTOR ? y_in[DW-1] : !z_in[ZW-1];
  end

  // micro-rotation
  always_ff @(posedge clk) begin
    if (ccw) begin
      x_out <= x_in - dx;
      y_out <= y_in + dy;
      z_out <= z_in - STEP;
    end else begin
      x_out <= x_in + dx;
      y_out <= y_in - dy;
      z_out <= z_in + STEP;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rrpc_div_cell.sv =====
// ----------------------------------------------------------------------------
// Mask divider cell
// One restoring-division step: yields one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rrpc_div_cell import rrpc_pkg::*; #(
  parameter bit FIRST = 1'b0
) (
  input  logic      clk,
  input  div_beat_t b_in,
  output div_beat_t b_out
);

  logic [Q_W-1:0] t;
  logic           qb;

  // trial subtract
  always_comb begin
    t  = FIRST ? b_in.rem : {b_in.rem[Q_W-2:0], 1'b0};
    qb = t >= {1'b0, b_in.w};
  end

  // hand the partial result on
  always_ff @(posedge clk) begin
    b_out.kill <= b_in.kill;
    b_out.w    <= b_in.w;
    b_out.rem  <= qb ? (t - {1'b0, b_in.w}) : t;
    b_out.quo  <= {b_in.quo[Q_W-2:0], qb};
  end

endmodule

`default_nettype wire

// ===== rtl/core/rrpc_delay.sv =====
// ----------------------------------------------------------------------------
// Alignment delay
// Fixed-length shift line that keeps side data in step with the chains.
// ----------------------------------------------------------------------------
`default_nettype none

module rrpc_delay import rrpc_pkg::*; #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  // shift line
  always_ff @(posedge clk) begin
    taps[0] <= d;
    for (int k = 1; k < DEPTH; k++) begin
      taps[k] <= taps[k-1];
    end
  end

  assign q = taps[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/core/rainbow_ring_pixel_color.sv =====
// ----------------------------------------------------------------------------
// Rainbow ring pixel color
// Procedural RGB color of one LED matrix pixel from its position and phase.
// ----------------------------------------------------------------------------
// A new pixel may be started in every clock cycle; busy is high during reset
// and for the first cycle after it. Each pixel's color appears on
// red/green/blue with done high for one cycle only, as the pixel leaves the
// last pipeline stage, and the receiver has no way to hold it off. The
// latency is set by the 16-cell vectoring chain, the 17-cell mask divider
// and the multiply stages behind it; the rotation chains for the color
// cosines run alongside. Ring registers are written over the cfg port and
// must only change while no pixel is in flight.
`default_nettype none
`include "rainbow_ring_pixel_color_assert.svh"

module rainbow_ring_pixel_color import rrpc_pkg::*; #(
  parameter int MATRIX_WIDTH  = DEFAULT_MATRIX_WIDTH,
  parameter int MATRIX_HEIGHT = DEFAULT_MATRIX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [$clog2(MATRIX_WIDTH)-1:0]  pixel_x,
  input  logic [$clog2(MATRIX_HEIGHT)-1:0] pixel_y,
  input  logic [15:0]                      time_phase,
  output logic                             done,
  output logic [7:0]                       red,
  output logic [7:0]                       green,
  output logic [7:0]                       blue,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_index,
  input  logic [12:0]                      cfg_data
);

  localparam int PXW    = $clog2(MATRIX_WIDTH);
  localparam int PYW    = $clog2(MATRIX_HEIGHT);
  localparam int STAGES = 38;

  localparam logic signed [ROT_W-1:0] ONE_R = ROT_W'(65536);
  localparam logic signed [ROT_W-1:0] GAIN_R = ROT_W'(CORDIC_GAIN_INV);
  localparam logic [15:0] OFS_GREEN = 16'd21845;
  localparam logic [15:0] OFS_BLUE  = 16'd43691;

  // fold a turn angle into the right half plane
  function automatic logic signed [ANG_W-1:0] fold_angle(input logic [15:0] a);
    logic [15:0] f;
    f = (a[15] ^ a[14]) ? (a ^ 16'h8000) : a;
    return ANG_W'(signed'(f));
  endfunction

  // undo the fold and clamp to [-1, 1]
  function automatic logic signed [COS_W-1:0] finish_cos(
    input logic signed [ROT_W-1:0] x, input logic neg);
    logic signed [ROT_W-1:0] v;
    v = neg ? -x : x;
    if (v > ONE_R) v = ONE_R;
    if (v < -ONE_R) v = -ONE_R;
    return COS_W'(v);
  endfunction

  logic            accept;
  logic [STAGES:0] vld;
  logic [12:0]     ring_radius;
  logic [11:0]     ring_width;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign done      = vld[STAGES];

  // control: busy out of reset, valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[STAGES-1:0], accept};
    end
  end

  // configuration beats
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_radius <= RING_RADIUS_RESET;
      ring_width  <= RING_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RING_RADIUS: ring_radius <= cfg_data;
        REG_RING_WIDTH:  ring_width  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // centred coordinate tables, worked out at elaboration
  logic signed [VEC_W-1:0] xtab [2**PXW];
  logic signed [VEC_W-1:0] ytab [2**PYW];

  for (genvar k = 0; k < 2**PXW; k++) begin : g_xtab
    assign xtab[k] = VEC_W'(((2 * k - MATRIX_WIDTH) * 32768) / MATRIX_HEIGHT);
  end
  for (genvar k = 0; k < 2**PYW; k++) begin : g_ytab
    assign ytab[k] = VEC_W'(((2 * k - MATRIX_HEIGHT) * 32768) / MATRIX_HEIGHT);
  end

  // stage 0: right half plane entry, pulse angle
  logic signed [VEC_W-1:0] vx [CORDIC_ITERS+1];
  logic signed [VEC_W-1:0] vy [CORDIC_ITERS+1];
  logic signed [15:0]      vz [CORDIC_ITERS+1];
  logic signed [ROT_W-1:0] px [CORDIC_ITERS+1];
  logic signed [ROT_W-1:0] py [CORDIC_ITERS+1];
  logic signed [ANG_W-1:0] pz [CORDIC_ITERS+1];
  logic signed [VEC_W-1:0] x_raw;
  logic signed [VEC_W-1:0] y_raw;
  logic [15:0]             pulse_ang;
  logic [15:0]             phase0;
  logic                    pneg0;

  always_comb begin
    x_raw     = xtab[pixel_x];
    y_raw     = ytab[pixel_y];
    pulse_ang = {time_phase[14:0], 1'b0} - 16'h4000;
  end

  always_ff @(posedge clk) begin
    vx[0]  <= x_raw[VEC_W-1] ? -x_raw : x_raw;
    vy[0]  <= x_raw[VEC_W-1] ? -y_raw : y_raw;
    vz[0]  <= x_raw[VEC_W-1] ? 16'sh8000 : 16'sh0000;
    phase0 <= time_phase;
    px[0]  <= GAIN_R;
    py[0]  <= '0;
    pz[0]  <= fold_angle(pulse_ang);
    pneg0  <= pulse_ang[15] ^ pulse_ang[14];
  end

  // stages 1..16: vectoring chain and pulse rotation chain
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_vec
    rrpc_cordic_cell #(.DW(VEC_W), .ZW(16), .ITER(i), .VECTOR(1'b1)) u_vec (
      .clk(clk), .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
      .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1])
    );
    rrpc_cordic_cell #(.DW(ROT_W), .ZW(ANG_W), .ITER(i), .VECTOR(1'b0)) u_pls (
      .clk(clk), .x_in(px[i]), .y_in(py[i]), .z_in(pz[i]),
      .x_out(px[i+1]), .y_out(py[i+1]), .z_out(pz[i+1])
    );
  end

  logic [15:0] phase16;
  logic        pneg16;

  rrpc_delay #(.W(16), .DEPTH(CORDIC_ITERS)) u_dly_phase (
    .clk(clk), .d(phase0), .q(phase16)
  );
  rrpc_delay #(.W(1), .DEPTH(CORDIC_ITERS)) u_dly_pneg (
    .clk(clk), .d(pneg0), .q(pneg16)
  );

  // stage 17: radius, pulse factor, color angles
  logic signed [VEC_W+17:0] rad_prod;
  logic signed [VEC_W-1:0]  rad17;
  logic signed [COS_W-1:0]  pcos;
  logic signed [COS_W:0]    psum;
  logic [Q_W-1:0]           p17;
  logic [15:0]              ang_base;
  logic [15:0]              ang_ch [3];
  logic signed [ROT_W-1:0]  rx [3][CORDIC_ITERS+1];
  logic signed [ROT_W-1:0]  ry [3][CORDIC_ITERS+1];
  logic signed [ANG_W-1:0]  rz [3][CORDIC_ITERS+1];
  logic                     rneg17 [3];

  always_comb begin
    rad_prod  = vx[CORDIC_ITERS] * $signed({1'b0, CORDIC_GAIN_INV});
    pcos      = finish_cos(px[CORDIC_ITERS], pneg16);
    psum      = (COS_W+1)'(49152) + (COS_W+1)'(pcos >>> 2);
    ang_base  = vz[CORDIC_ITERS] + phase16;
    ang_ch[0] = ang_base;
    ang_ch[1] = ang_base + OFS_GREEN;
    ang_ch[2] = ang_base + OFS_BLUE;
  end

  always_ff @(posedge clk) begin
    rad17 <= VEC_W'(rad_prod >>> 16);
    p17   <= psum[Q_W-1:0];
  end

  // three color channels: rotation chains, stages 18..33
  logic signed [COS_W-1:0] cfin [3];
  logic [Q_W-1:0]          c34 [3];
  logic [Q_W-1:0]          c35 [3];
  logic [ROT_W-1:0]        csum [3];
  logic                    rneg33 [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    always_ff @(posedge clk) begin
      rx[ch][0]  <= GAIN_R;
      ry[ch][0]  <= '0;
      rz[ch][0]  <= fold_angle(ang_ch[ch]);
      rneg17[ch] <= ang_ch[ch][15] ^ ang_ch[ch][14];
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
      rrpc_cordic_cell #(.DW(ROT_W), .ZW(ANG_W), .ITER(i), .VECTOR(1'b0)) u_rot (
        .clk(clk), .x_in(rx[ch][i]), .y_in(ry[ch][i]), .z_in(rz[ch][i]),
        .x_out(rx[ch][i+1]), .y_out(ry[ch][i+1]), .z_out(rz[ch][i+1])
      );
    end

    rrpc_delay #(.W(1), .DEPTH(CORDIC_ITERS)) u_dly_rneg (
      .clk(clk), .d(rneg17[ch]), .q(rneg33[ch])
    );

    // stage 34: channel level 0.5 + 0.5 cos, stage 35: align with mask
    always_comb begin
      cfin[ch] = finish_cos(rx[ch][CORDIC_ITERS], rneg33[ch]);
      csum[ch] = ONE_R + ROT_W'(cfin[ch]);
    end

    always_ff @(posedge clk) begin
      c34[ch] <= csum[ch][Q_W:1];
      c35[ch] <= c34[ch];
    end
  end

  // stage 18: ring distance against half width
  localparam int DIV_LEN = Q_W;

  logic signed [VEC_W:0] ring_diff;
  logic [VEC_W:0]        dist_abs;
  logic [W_W-1:0]        w_q16;
  div_beat_t             div [DIV_LEN+1];

  always_comb begin
    ring_diff = (VEC_W+1)'(rad17) - $signed({{(VEC_W-16){1'b0}}, ring_radius, 4'b0});
    dist_abs  = ring_diff[VEC_W] ? -ring_diff : ring_diff;
    w_q16     = {ring_width, 4'b0};
  end

  always_ff @(posedge clk) begin
    div[0].kill <= dist_abs >= (VEC_W+1)'(w_q16);
    div[0].w    <= w_q16;
    div[0].rem  <= {1'b0, w_q16 - dist_abs[W_W-1:0]};
    div[0].quo  <= '0;
  end

  // stages 19..35: mask divider chain
  for (genvar k = 0; k < DIV_LEN; k++) begin : g_div
    rrpc_div_cell #(.FIRST(k == 0)) u_div (
      .clk(clk), .b_in(div[k]), .b_out(div[k+1])
    );
  end

  logic [Q_W-1:0] mask;
  logic [Q_W-1:0] p36;

  assign mask = div[DIV_LEN].kill ? '0 : div[DIV_LEN].quo;

  rrpc_delay #(.W(Q_W), .DEPTH(19)) u_dly_pulse (
    .clk(clk), .d(p17), .q(p36)
  );

  // stages 36..38: weight by mask, by pulse, scale to eight bits
  logic [2*Q_W-1:0] prod_m [3];
  logic [2*Q_W-1:0] prod_p [3];
  logic [24:0]      prod_o [3];
  logic [Q_W-1:0]   m1 [3];
  logic [Q_W-1:0]   v37 [3];
  logic [7:0]       o38 [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_out
    always_comb begin
      prod_m[ch] = c35[ch] * mask;
      prod_p[ch] = m1[ch] * p36;
      prod_o[ch] = v37[ch] * 8'd255;
    end

    always_ff @(posedge clk) begin
      m1[ch]  <= prod_m[ch][32:16];
      v37[ch] <= prod_p[ch][32:16];
      o38[ch] <= prod_o[ch][23:16];
    end
  end

  assign red   = o38[0];
  assign green = o38[1];
  assign blue  = o38[2];

  // checks
  `RRPC_ASSERT_IMPLY(a_done_latency, clk, rst, done, $past(accept, STAGES + 1))
  `RRPC_ASSERT_IMPLY(a_busy_only_reset, clk, rst, !$past(rst), !busy)
  `RRPC_ASSERT_IMPLY(a_pulse_floor, clk, rst, vld[17], p17 >= 17'd32768)
  `RRPC_ASSERT_NEXT(a_mask_zero_dark, clk, rst, vld[35] && mask == '0,
    m1[0] == '0 && m1[1] == '0 && m1[2] == '0)

endmodule

`default_nettype wire

// ===== bench/rainbow_ring_pixel_color_tb.sv =====
// ----------------------------------------------------------------------------
// Rainbow ring pixel color testbench
// Streams pixel coordinates and phases into the color block in random bursts,
// rewrites the ring registers between drained phases, and checks every color
// beat against a cycle-free fixed-point color predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rainbow_ring_pixel_color_tb import rrpc_pkg::*;;

  localparam int MAT_W    = 64;
  localparam int MAT_H    = 32;
  localparam int LATENCY  = 39;
  localparam int WD_LIMIT = 4000;

  typedef enum logic [1:0] {JOB_PIXEL, JOB_CFG, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t   kind;
    logic [5:0]  x;
    logic [4:0]  y;
    logic [15:0] phase;
    cfg_reg_t    idx;
    logic [12:0] data;
  } job_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [5:0]  pixel_x = '0;
  logic [4:0]  pixel_y = '0;
  logic [15:0] time_phase = '0;
  logic        done;
  logic [7:0]  red, green, blue;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_reg_t    cfg_index = REG_RING_RADIUS;
  logic [12:0] cfg_data = '0;

  job_t   jobs[$];
  rgb_t   colors_due[$];
  logic [12:0] ring_radius_q = RING_RADIUS_RESET;
  logic [11:0] ring_width_q  = RING_WIDTH_RESET;
  int     mismatches = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     idle_cycles = 0;

  rainbow_ring_pixel_color #(
    .MATRIX_WIDTH (MAT_W),
    .MATRIX_HEIGHT(MAT_H)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .time_phase(time_phase),
    .done      (done),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // cordic cosine of a 16-bit turn angle, q16, clamped to +-1
  function automatic longint cos_turn16(logic [15:0] ang);
    longint a, x, y, dx, dy;
    bit neg;
    a = ang;
    x = 39797;
    y = 0;
    neg = 0;
    if (a >= 16384 && a < 49152) begin
      neg = 1;
      a -= 32768;
    end else if (a >= 49152) begin
      a -= 65536;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; a += longint'(ATAN_TURNS[i]);
      end
    end
    if (neg) x = -x;
    if (x > 65536) x = 65536;
    if (x < -65536) x = -65536;
    return x;
  endfunction

  // one color channel from cosine, ring mask and pulse
  function automatic logic [7:0] shade(longint cosv, longint mask, longint pulse);
    longint c, v, o;
    c = (65536 + cosv) >>> 1;
    v = (((c * mask) >>> 16) * pulse) >>> 16;
    if (v < 0) v = 0;
    if (v > 65536) v = 65536;
    o = (v * 255) >>> 16;
    if (o > 255) o = 255;
    return o[7:0];
  endfunction

  // expected color of one pixel under the current ring settings
  function automatic rgb_t pixel_color(logic [5:0] px, logic [4:0] py, logic [15:0] ph);
    longint x, y, z, dx, dy, radius, d, w, mask, pulse;
    logic [15:0] angle;
    rgb_t res;
    x = ((2 * longint'(px) - MAT_W) * 32768) / MAT_H;
    y = ((2 * longint'(py) - MAT_H) * 32768) / MAT_H;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32768;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
      end
    end
    radius = (x * 39797) >>> 16;
    angle = z[15:0];
    d = radius - longint'(ring_radius_q) * 16;
    if (d < 0) d = -d;
    w = longint'(ring_width_q) * 16;
    // zero width lands here too and gives a dark pixel
    mask = (d >= w) ? 0 : ((w - d) << 16) / w;
    pulse = 49152 + (cos_turn16(16'(2 * ph - 16'd16384)) >>> 2);
    res.r = shade(cos_turn16(16'(angle + ph)), mask, pulse);
    res.g = shade(cos_turn16(16'(angle + ph + 16'd21845)), mask, pulse);
    res.b = shade(cos_turn16(16'(angle + ph + 16'd43691)), mask, pulse);
    return res;
  endfunction

  task automatic add_pixel(logic [5:0] x, logic [4:0] y, logic [15:0] ph);
    job_t j;
    j.kind = JOB_PIXEL; j.x = x; j.y = y; j.phase = ph;
    j.idx = REG_RING_RADIUS; j.data = '0;
    jobs.push_back(j);
  endtask

  task automatic add_cfg(cfg_reg_t idx, logic [12:0] data);
    job_t j;
    j.kind = JOB_CFG; j.x = '0; j.y = '0; j.phase = '0; j.idx = idx; j.data = data;
    jobs.push_back(j);
  endtask

  task automatic add_random_pixels(int n);
    for (int i = 0; i < n; i++)
      add_pixel(6'($urandom), 5'($urandom), 16'($urandom));
  endtask

  // driver: pixel beats in bursts, register writes only once drained
  always @(posedge clk) begin
    logic acc, cacc;
    acc  = start && !busy;
    cacc = cfg_valid && cfg_ready;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (acc) colors_due.push_back(pixel_color(pixel_x, pixel_y, time_phase));
      if (cacc) begin
        if (cfg_index == REG_RING_RADIUS) ring_radius_q <= cfg_data;
        else ring_width_q <= cfg_data[11:0];
      end
      if ((start && !acc) || (cfg_valid && !cacc)) begin
        // hold the current beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (jobs.size() == 0) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (jobs[0].kind == JOB_PIXEL) begin
        start <= 1'b1;
        cfg_valid <= 1'b0;
        pixel_x <= jobs[0].x;
        pixel_y <= jobs[0].y;
        time_phase <= jobs[0].phase;
        void'(jobs.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else if (colors_due.size() != 0 || acc) begin
        // wait for the pipeline to empty
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (jobs[0].kind == JOB_CFG) begin
        start <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= jobs[0].idx;
        cfg_data <= jobs[0].data;
        void'(jobs.pop_front());
      end else begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
        void'(jobs.pop_front());
      end
    end
  end

  // monitor: compare each color beat with the oldest prediction
  always @(posedge clk) begin
    rgb_t exp_c;
    if (!rst && done) begin
      if (colors_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected color beat r=%0d g=%0d b=%0d", red, green, blue);
      end else begin
        exp_c = colors_due.pop_front();
        if (exp_c.r !== red || exp_c.g !== green || exp_c.b !== blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     exp_c.r, exp_c.g, exp_c.b, red, green, blue);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus plan and end of run
  initial begin
    job_t dj;
    burst_left = $urandom_range(1, 40);
    // corners, centre and phase quadrants at reset settings
    add_pixel(6'd0, 5'd0, 16'd0);
    add_pixel(6'd63, 5'd0, 16'd16384);
    add_pixel(6'd0, 5'd31, 16'd32768);
    add_pixel(6'd63, 5'd31, 16'd49152);
    add_pixel(6'd32, 5'd16, 16'd65535);
    add_pixel(6'd32, 5'd16, 16'd0);
    add_pixel(6'd40, 5'd16, 16'd8192);
    add_pixel(6'd32, 5'd20, 16'd21845);
    add_pixel(6'd22, 5'd16, 16'd43691);
    add_pixel(6'd32, 5'd11, 16'd1);
    // zero ring width gives dark pixels
    add_cfg(REG_RING_WIDTH, 13'd0);
    add_pixel(6'd40, 5'd16, 16'd100);
    add_pixel(6'd32, 5'd16, 16'd30000);
    // widest ring around the centre
    add_cfg(REG_RING_RADIUS, 13'd0);
    add_cfg(REG_RING_WIDTH, 13'h1FFF);
    add_pixel(6'd32, 5'd16, 16'd5000);
    add_pixel(6'd0, 5'd0, 16'd60000);
    add_pixel(6'd63, 5'd31, 16'd12345);
    // largest radius, narrowest ring
    add_cfg(REG_RING_RADIUS, 13'h1FFF);
    add_cfg(REG_RING_WIDTH, 13'd1);
    add_pixel(6'd0, 5'd0, 16'd0);
    add_pixel(6'd63, 5'd0, 16'd0);
    // back to reset settings and a forced drain
    add_cfg(REG_RING_RADIUS, 13'(RING_RADIUS_RESET));
    add_cfg(REG_RING_WIDTH, 13'(RING_WIDTH_RESET));
    dj.kind = JOB_DRAIN; dj.x = '0; dj.y = '0; dj.phase = '0;
    dj.idx = REG_RING_RADIUS; dj.data = '0;
    jobs.push_back(dj);
    add_random_pixels(80);
    // wide ring, big radius
    add_cfg(REG_RING_RADIUS, 13'd6000);
    add_cfg(REG_RING_WIDTH, 13'd4095);
    add_random_pixels(80);
    // random settings, upper data bits random too
    for (int k = 0; k < 4; k++) begin
      add_cfg(REG_RING_RADIUS, 13'($urandom_range(0, 8191)));
      add_cfg(REG_RING_WIDTH, 13'($urandom_range(0, 8191)));
      add_random_pixels(80);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (jobs.size() != 0 || start || cfg_valid || colors_due.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (colors_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rrpc_pkg.sv
rtl/core/rrpc_cordic_cell.sv
rtl/core/rrpc_div_cell.sv
rtl/core/rrpc_delay.sv
rtl/core/rainbow_ring_pixel_color.sv
bench/rainbow_ring_pixel_color_tb.sv
